// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, sampled on the rising edge, off while reset is asserted.
`define U8_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Valid and a signal hold while their channel is stalled.
`define U8_ASSERT_STALL(name, clk, rst_n, vld, rdy, sig, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy) |=> (vld) && $stable(sig))) \
		else $error(msg);

`endif

// ===== hw/rtl/u8enc_pkg.sv =====
package u8enc_pkg;

	// Field widths
	localparam int unsigned CpW   = 32;
	localparam int unsigned MaxW  = 21;
	localparam int unsigned ByteW = 8;

	localparam logic [MaxW-1:0] MAX_CP_RESET = 21'h10FFFF;

	// Filter ranges
	localparam logic [CpW-1:0] SURR_LO  = 32'h0000_D800;
	localparam logic [CpW-1:0] SURR_HI  = 32'h0000_DFFF;
	localparam logic [CpW-1:0] NONCH_LO = 32'h0000_FDD0;
	localparam logic [CpW-1:0] NONCH_HI = 32'h0000_FDEF;
	// bits 15:1 all set means low half is FFFE or FFFF
	localparam logic [14:0]    NONCH_TAIL = 15'h7FFF;

	// Sequence length limits
	localparam logic [CpW-1:0] LIM_1B = 32'h0000_0080;
	localparam logic [CpW-1:0] LIM_2B = 32'h0000_0800;
	localparam logic [CpW-1:0] LIM_3B = 32'h0001_0000;

	// Queue between front and back
	localparam int unsigned QDepth = 2;
	localparam int unsigned QPtrW  = 1;
	localparam int unsigned QCntW  = QPtrW + 1;

	// Index of the final byte of a sequence
	typedef enum logic [1:0] {
		LEN_1 = 2'd0,
		LEN_2 = 2'd1,
		LEN_3 = 2'd2,
		LEN_4 = 2'd3
	} seq_len_t;

	// One encoded code point, byte 0 is the lead byte
	typedef struct packed {
		logic [3:0][ByteW-1:0] bytes;
		seq_len_t              last_idx;
	} seq_t;

endpackage

// ===== hw/rtl/u8enc_cp_if.sv =====
interface u8enc_cp_if;
	import u8enc_pkg::*;

	logic           valid;
	logic           ready;
	logic [CpW-1:0] code_point;

	modport source (output valid, output code_point, input ready);
	modport sink   (input valid, input code_point, output ready);
endinterface

// ===== hw/rtl/u8enc_byte_if.sv =====
interface u8enc_byte_if;
	import u8enc_pkg::*;

	logic             valid;
	logic             ready;
	logic [ByteW-1:0] out_byte;
	logic             last_byte;

	modport source (output valid, output out_byte, output last_byte, input ready);
	modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/utf8_encoder_with_filter.sv =====
// UTF-8 encoder with code point filter. Each item on cp_ch is one 32-bit code
// point; its UTF-8 encoding leaves on byte_ch one byte per item, lead byte first,
// with last_byte set on the final byte. Code points above max_code_point (written
// through cfg_we/cfg_wdata, reset 0x10FFFF), surrogates D800-DFFF, noncharacters
// FDD0-FDEF and values whose low 16 bits are FFFE or FFFF produce no output.
// The input side takes a new code point every cycle while the two-entry queue
// has room; the serializer sends one byte per cycle while byte_ch is ready,
// so an accepted code point takes its byte count (1 to 4) of output slots and
// a dropped one none. A code point passes the input register, the queue, the
// sequence register and the output byte register before its first byte shows.
module utf8_encoder_with_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [u8enc_pkg::MaxW-1:0] cfg_wdata,
	u8enc_cp_if.sink                  cp_ch,
	u8enc_byte_if.source              byte_ch
);
	import u8enc_pkg::*;

	seq_t push_data;
	logic push_valid;
	logic push_ready;
	seq_t pop_data;
	logic pop_valid;
	logic pop;

	u8enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cp_ch      (cp_ch),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	u8enc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop        (pop)
	);

	u8enc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop       (pop),
		.byte_ch   (byte_ch)
	);

endmodule

// ===== hw/rtl/u8enc_front.sv =====
module u8enc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [u8enc_pkg::MaxW-1:0] cfg_wdata,
	u8enc_cp_if.sink                  cp_ch,
	output u8enc_pkg::seq_t           push_data,
	output logic                      push_valid,
	input  logic                      push_ready
);
	import u8enc_pkg::*;

	logic [MaxW-1:0] max_q;
	logic [CpW-1:0]  cp_s1;
	logic            vld_s1;
	logic            drop_s1;
	logic            take;
	logic [MaxW-1:0] c;

	// Limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_CP_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// Input stage: refills whenever it is empty or the held item leaves or is dropped
	assign take        = !vld_s1 || drop_s1 || push_ready;
	assign cp_ch.ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= cp_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && cp_ch.valid) begin
			cp_s1 <= cp_ch.code_point;
		end
	end

	// Filter
	always_comb begin
		drop_s1 = 1'b0;
		if (cp_s1 > {{(CpW-MaxW){1'b0}}, max_q}) drop_s1 = 1'b1;
		if (cp_s1[15:1] == NONCH_TAIL) drop_s1 = 1'b1;
		if (cp_s1 >= SURR_LO && cp_s1 <= SURR_HI) drop_s1 = 1'b1;
		if (cp_s1 >= NONCH_LO && cp_s1 <= NONCH_HI) drop_s1 = 1'b1;
	end

	// Encode; only values up to 21 bits survive the filter
	assign c = cp_s1[MaxW-1:0];

	always_comb begin
		push_data = '0;
		if (cp_s1 < LIM_1B) begin
			push_data.bytes[0] = {1'b0, c[6:0]};
			push_data.last_idx = LEN_1;
		end else if (cp_s1 < LIM_2B) begin
			push_data.bytes[0] = {3'b110, c[10:6]};
			push_data.bytes[1] = {2'b10, c[5:0]};
			push_data.last_idx = LEN_2;
		end else if (cp_s1 < LIM_3B) begin
			push_data.bytes[0] = {4'b1110, c[15:12]};
			push_data.bytes[1] = {2'b10, c[11:6]};
			push_data.bytes[2] = {2'b10, c[5:0]};
			push_data.last_idx = LEN_3;
		end else begin
			push_data.bytes[0] = {5'b11110, c[20:18]};
			push_data.bytes[1] = {2'b10, c[17:12]};
			push_data.bytes[2] = {2'b10, c[11:6]};
			push_data.bytes[3] = {2'b10, c[5:0]};
			push_data.last_idx = LEN_4;
		end
	end

	assign push_valid = vld_s1 && !drop_s1;

endmodule

// ===== hw/rtl/u8enc_queue.sv =====
module u8enc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  u8enc_pkg::seq_t push_data,
	input  logic            push_valid,
	output logic            push_ready,
	output u8enc_pkg::seq_t pop_data,
	output logic            pop_valid,
	input  logic            pop
);
	import u8enc_pkg::*;

	seq_t             mem_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = cnt_q != QCntW'(QDepth);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/u8enc_back.sv =====
module u8enc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  u8enc_pkg::seq_t pop_data,
	input  logic            pop_valid,
	output logic            pop,
	u8enc_byte_if.source    byte_ch
);
	import u8enc_pkg::*;

	seq_t             ent_q;
	logic [1:0]       idx_q;
	logic             busy_q;
	logic             ov_q;
	logic [ByteW-1:0] ob_q;
	logic             ol_q;
	logic             out_free;
	logic             cur_last;
	logic             load;

	assign out_free = !ov_q || byte_ch.ready;
	assign cur_last = idx_q == 2'(ent_q.last_idx);
	// next item loads on the cycle its predecessor's last byte goes out
	assign load     = out_free && (!busy_q || cur_last) && pop_valid;
	assign pop      = load;

	// Sequencer control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			ov_q   <= 1'b0;
		end else if (out_free) begin
			ov_q <= busy_q;
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q && cur_last) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Current sequence and output byte
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= pop_data;
		end
		if (out_free && busy_q) begin
			ob_q <= ent_q.bytes[idx_q];
			ol_q <= cur_last;
		end
	end

	assign byte_ch.valid     = ov_q;
	assign byte_ch.out_byte  = ob_q;
	assign byte_ch.last_byte = ol_q;

endmodule

// ===== hw/rtl/u8enc_checker.sv =====
`include "assert_macros.svh"

module u8enc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last_byte
);
	import u8enc_pkg::*;

	// Set when the next byte must open a new sequence
	logic lead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			lead_q <= last_byte;
		end
	end

	`U8_ASSERT(a_lead_form, clk, arst_n, out_valid && lead_q |-> out_byte[7:6] != 2'b10, "continuation byte where a lead byte was due")
	`U8_ASSERT(a_cont_form, clk, arst_n, out_valid && !lead_q |-> out_byte[7:6] == 2'b10, "lead byte inside a sequence")
	`U8_ASSERT(a_multi_not_last, clk, arst_n, out_valid && out_byte[7:6] == 2'b11 |-> !last_byte, "multi-byte lead marked last")
	`U8_ASSERT_STALL(a_hold_byte, clk, arst_n, out_valid, out_ready, out_byte, "out_byte changed while stalled")
	`U8_ASSERT_STALL(a_hold_last, clk, arst_n, out_valid, out_ready, last_byte, "last_byte changed while stalled")

endmodule

bind utf8_encoder_with_filter u8enc_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (byte_ch.valid),
	.out_ready (byte_ch.ready),
	.out_byte  (byte_ch.out_byte),
	.last_byte (byte_ch.last_byte)
);
